FILE: hdl/two_level_page_table_walker_unit_defines.svh
// assertion macros for the page table walker
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked outside of reset
`define TLPW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every edge, reset included
`define TLPW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLPW_ASSERT(label, clk, rst_n, prop, msg)
`define TLPW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: hdl/tlpw_pkg.sv
`default_nettype none

package tlpw_pkg;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MMU_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_PROTECT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_PROTECT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SPLIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE_ZERO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE_ONE  = 3'd5;

    // request action codes
    localparam logic ACT_TRANSLATE = 1'b0;
    localparam logic ACT_REPLY     = 1'b1;

    // response kind codes
    localparam logic KIND_FETCH = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // fault codes
    localparam logic [2:0] FAULT_NONE         = 3'd0;
    localparam logic [2:0] FAULT_SECTION_XLAT = 3'd1;
    localparam logic [2:0] FAULT_PAGE_XLAT    = 3'd2;
    localparam logic [2:0] FAULT_SECTION_PERM = 3'd3;
    localparam logic [2:0] FAULT_PAGE_PERM    = 3'd4;

    // descriptor type codes
    localparam logic [1:0] L1_FAULT   = 2'd0;
    localparam logic [1:0] L1_TABLE   = 2'd1;
    localparam logic [1:0] L1_SECTION = 2'd2;
    localparam logic [1:0] L2_FAULT   = 2'd0;
    localparam logic [1:0] L2_LARGE   = 2'd1;

    // access permission codes
    localparam logic [1:0] AP_NONE     = 2'd0;
    localparam logic [1:0] AP_PRIV     = 2'd1;
    localparam logic [1:0] AP_USER_RO  = 2'd2;

    // address masks
    localparam logic [31:0] MASK_L2_TABLE    = 32'hFFFF_FC00;
    localparam logic [31:0] MASK_L2_INDEX    = 32'h000F_F000;
    localparam logic [31:0] MASK_LARGE_PAGE  = 32'hFFFF_0000;
    localparam logic [31:0] MASK_SMALL_PAGE  = 32'hFFFF_F000;
    localparam logic [31:0] MASK_SUPERSECT   = 32'hFF00_0000;
    localparam logic [31:0] MASK_SECTION     = 32'hFFF0_0000;
    localparam logic [31:0] MASK_SUPER_FLAG  = 32'h0003_0000;
    localparam logic [31:0] MASK_L1_BASE_ONE = 32'hFFFF_C000;
    localparam logic [31:0] MASK_ALL         = 32'hFFFF_FFFF;
    localparam logic [31:0] MASK_WORD        = 32'hFFFF_FFFC;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_L1   = 2'd1,
        PH_L2   = 2'd2
    } t_walk_phase;

    typedef struct packed {
        logic        action;
        logic [31:0] virtual_address;
        logic        access_read;
        logic        user_mode;
        logic [31:0] descriptor;
    } t_walk_req;

    typedef struct packed {
        logic        kind;
        logic [31:0] fetch_address;
        logic [31:0] physical_address;
        logic [2:0]  fault;
    } t_walk_rsp;

endpackage

`default_nettype wire

FILE: hdl/two_level_page_table_walker_unit.sv
// Two-level page table walker without a TLB. Every request, a translate or a
// returned descriptor word, is taken and its response (a
// descriptor fetch address or a finished translation with fault code) shows
// in the output register on the next cycle; a new request can be taken every
// cycle, including the cycle in which the output register hands its response
// over, so throughput is one request per clock. The
// only thing that holds the input back is a response held in the output
// register by a downstream stall. A descriptor reply arriving with no walk in
// progress produces no response, and a translate request during a walk drops
// that walk. Configuration writes take effect on the next edge.
`default_nettype none

`include "two_level_page_table_walker_unit_defines.svh"

module two_level_page_table_walker_unit
    import tlpw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  wire logic                  i_req_valid,
    output      logic                  o_req_stall,
    input  wire t_walk_req             i_req,
    // response channel
    output      logic                  o_rsp_valid,
    input  wire logic                  i_rsp_stall,
    output      t_walk_rsp             o_rsp
);

    logic        r_mmu_enable;
    logic        r_system_protect;
    logic        r_rom_protect;
    logic [2:0]  r_table_split;
    logic [31:0] r_table_base_zero;
    logic [31:0] r_table_base_one;

    t_walk_phase r_phase, n_phase;
    logic [31:0] r_saved_address;
    logic        r_saved_read;
    logic        r_saved_user;

    logic        r_rsp_valid;
    t_walk_rsp   r_rsp;
    logic        n_rsp_valid;
    t_walk_rsp   n_rsp;

    logic        w_req_accept;

    logic [31:0] w_split_mask;
    logic [31:0] w_base_zero_mask;
    logic [31:0] w_l1_address;
    logic [31:0] w_l2_address;
    logic [31:0] w_section_pa;
    logic [31:0] w_page_pa;
    logic        w_section_ok;
    logic        w_page_ok;
    logic [1:0]  w_desc_type;

    // permission check on the saved access
    function automatic logic perm_ok(
        input logic [1:0] ap,
        input logic       rd,
        input logic       usr,
        input logic       s_bit,
        input logic       r_bit
    );
        logic ok;
        unique case (ap)
            AP_NONE:    ok = rd && ((s_bit && !usr) || r_bit);
            AP_PRIV:    ok = !usr;
            AP_USER_RO: ok = rd || !usr;
            default:    ok = 1'b1;
        endcase
        return ok;
    endfunction

    // handshake: input waits only on a held response
    assign o_req_stall  = r_rsp_valid && i_rsp_stall;
    assign w_req_accept = i_req_valid && !o_req_stall;
    assign o_rsp_valid  = r_rsp_valid;
    assign o_rsp        = r_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mmu_enable      <= 1'b0;
            r_system_protect  <= 1'b0;
            r_rom_protect     <= 1'b0;
            r_table_split     <= 3'd0;
            r_table_base_zero <= 32'd0;
            r_table_base_one  <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MMU_ENABLE:      r_mmu_enable      <= i_cfg_data[0];
                CFG_SYSTEM_PROTECT:  r_system_protect  <= i_cfg_data[0];
                CFG_ROM_PROTECT:     r_rom_protect     <= i_cfg_data[0];
                CFG_TABLE_SPLIT:     r_table_split     <= i_cfg_data[2:0];
                CFG_TABLE_BASE_ZERO: r_table_base_zero <= i_cfg_data[31:0];
                CFG_TABLE_BASE_ONE:  r_table_base_one  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // first-level descriptor address from the split
    assign w_split_mask     = MASK_ALL >> r_table_split;
    assign w_base_zero_mask = MASK_ALL << (5'd14 - {2'b00, r_table_split});

    always_comb begin
        if ((i_req.virtual_address & ~w_split_mask) != 32'd0) begin
            w_l1_address = (r_table_base_one & MASK_L1_BASE_ONE)
                         | (i_req.virtual_address >> 18);
        end else begin
            w_l1_address = (r_table_base_zero & w_base_zero_mask)
                         | ((i_req.virtual_address & w_split_mask) >> 18);
        end
    end

    // descriptor decode against the saved address
    assign w_desc_type  = i_req.descriptor[1:0];
    assign w_l2_address = ((i_req.descriptor & MASK_L2_TABLE)
                        | ((r_saved_address & MASK_L2_INDEX) >> 10)) & MASK_WORD;
    assign w_section_pa = ((i_req.descriptor & MASK_SUPER_FLAG) != 32'd0)
                        ? ((i_req.descriptor & MASK_SUPERSECT) | (r_saved_address & ~MASK_SUPERSECT))
                        : ((i_req.descriptor & MASK_SECTION) | (r_saved_address & ~MASK_SECTION));
    assign w_page_pa    = (w_desc_type == L2_LARGE)
                        ? ((i_req.descriptor & MASK_LARGE_PAGE) | (r_saved_address & ~MASK_LARGE_PAGE))
                        : ((i_req.descriptor & MASK_SMALL_PAGE) | (r_saved_address & ~MASK_SMALL_PAGE));
    assign w_section_ok = perm_ok(i_req.descriptor[11:10], r_saved_read, r_saved_user,
                                  r_system_protect, r_rom_protect);
    assign w_page_ok    = perm_ok(i_req.descriptor[5:4], r_saved_read, r_saved_user,
                                  r_system_protect, r_rom_protect);

    // walk phase next state
    always_comb begin
        n_phase = r_phase;
        if (w_req_accept) begin
            if (i_req.action == ACT_TRANSLATE) begin
                n_phase = r_mmu_enable ? PH_L1 : PH_IDLE;
            end else begin
                unique case (r_phase)
                    PH_L1:   n_phase = (w_desc_type == L1_TABLE) ? PH_L2 : PH_IDLE;
                    PH_L2:   n_phase = PH_IDLE;
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // response for the incoming request
    always_comb begin
        n_rsp_valid = 1'b1;
        n_rsp       = '{kind: KIND_DONE, fetch_address: 32'd0,
                        physical_address: 32'd0, fault: FAULT_NONE};
        if (i_req.action == ACT_TRANSLATE) begin
            if (r_mmu_enable) begin
                n_rsp.kind          = KIND_FETCH;
                n_rsp.fetch_address = w_l1_address & MASK_WORD;
            end else begin
                n_rsp.physical_address = i_req.virtual_address;
            end
        end else begin
            unique case (r_phase)
                PH_L1: begin
                    if (w_desc_type == L1_TABLE) begin
                        n_rsp.kind          = KIND_FETCH;
                        n_rsp.fetch_address = w_l2_address;
                    end else if (w_desc_type == L1_SECTION) begin
                        if (w_section_ok) begin
                            n_rsp.physical_address = w_section_pa;
                        end else begin
                            n_rsp.fault = FAULT_SECTION_PERM;
                        end
                    end else begin
                        n_rsp.fault = FAULT_SECTION_XLAT;
                    end
                end
                PH_L2: begin
                    if (w_desc_type == L2_FAULT) begin
                        n_rsp.fault = FAULT_PAGE_XLAT;
                    end else if (w_page_ok) begin
                        n_rsp.physical_address = w_page_pa;
                    end else begin
                        n_rsp.fault = FAULT_PAGE_PERM;
                    end
                end
                default: begin
                    n_rsp_valid = 1'b0;
                end
            endcase
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_saved_address <= 32'd0;
            r_saved_read    <= 1'b0;
            r_saved_user    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (w_req_accept && i_req.action == ACT_TRANSLATE) begin
                r_saved_address <= i_req.virtual_address;
                r_saved_read    <= i_req.access_read;
                r_saved_user    <= i_req.user_mode;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_req_accept) begin
            r_rsp_valid <= n_rsp_valid;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_accept && n_rsp_valid) begin
            r_rsp <= n_rsp;
        end
    end

    // checks
    `TLPW_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_phase == PH_IDLE && !r_rsp_valid), "walker not idle after reset")
    `TLPW_ASSERT(a_kind_matches_phase, i_clk, i_rst_n, r_rsp_valid |-> ((r_rsp.kind == KIND_DONE) == (r_phase == PH_IDLE)), "response kind disagrees with walk phase")
    `TLPW_ASSERT(a_idle_reply_silent, i_clk, i_rst_n, (w_req_accept && i_req.action == ACT_REPLY && r_phase == PH_IDLE) |=> !r_rsp_valid, "reply with no walk produced a response")
    `TLPW_ASSERT(a_flat_map, i_clk, i_rst_n, (w_req_accept && i_req.action == ACT_TRANSLATE && !r_mmu_enable) |=> (r_rsp_valid && r_rsp.physical_address == $past(i_req.virtual_address)), "untranslated address altered")
    `TLPW_ASSERT(a_fault_zero_pa, i_clk, i_rst_n, (r_rsp_valid && r_rsp.fault != FAULT_NONE) |-> (r_rsp.physical_address == 32'd0 && r_rsp.kind == KIND_DONE), "faulted response carries an address")

endmodule

`default_nettype wire

FILE: bench/tb_two_level_page_table_walker_unit.sv
`timescale 1ns / 100ps

module tb_two_level_page_table_walker_unit;
    import tlpw_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned WALK_PHASES  = 12;
    localparam int unsigned PHASE_ITEMS  = 43;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_req_valid = 1'b0;
    logic                  o_req_stall;
    t_walk_req             i_req = '0;
    logic                  o_rsp_valid;
    logic                  i_rsp_stall = 1'b0;
    t_walk_rsp             o_rsp;

    two_level_page_table_walker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always #6 i_clk = ~i_clk;

    // shadow of the walker: registers and the walk in progress
    logic        xlat_on    = 1'b0;
    logic        sys_prot   = 1'b0;
    logic        rom_prot   = 1'b0;
    logic [2:0]  split_n    = 3'd0;
    logic [31:0] base_zero  = 32'd0;
    logic [31:0] base_one   = 32'd0;
    t_walk_phase walk_phase = PH_IDLE;
    logic [31:0] walk_va    = 32'd0;
    logic        walk_read  = 1'b0;
    logic        walk_user  = 1'b0;

    t_walk_rsp   pending_rsp_q[$];
    int unsigned error_count = 0;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  stall_ticks = 8'd0;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    // access permission check against the saved request
    function automatic bit access_allowed(input logic [1:0] ap);
        case (ap)
            AP_NONE:    return walk_read && ((sys_prot && !walk_user) || rom_prot);
            AP_PRIV:    return !walk_user;
            AP_USER_RO: return walk_read || !walk_user;
            default:    return 1'b1;
        endcase
    endfunction

    // first-level descriptor address, base selected by the split bits
    function automatic logic [31:0] first_level_addr(input logic [31:0] va);
        int unsigned n;
        int unsigned sh;
        logic [31:0] a;
        logic [31:0] idx;
        n = {29'd0, split_n};
        if (n != 0 && (va >> (32 - n)) != 0) begin
            a = (base_one & MASK_L1_BASE_ONE) | (va >> 18);
        end else begin
            sh  = 14 - n;
            idx = va << n;
            idx = idx >> (18 + n);
            a   = ((base_zero >> sh) << sh) | idx;
        end
        return a & MASK_WORD;
    endfunction

    // one step of the walk; returns 1 when a response is due
    function automatic bit predict_walk_step(input t_walk_req rq, output t_walk_rsp rsp);
        logic [31:0] d;
        logic [31:0] pa;
        rsp = '0;
        if (rq.action == ACT_TRANSLATE) begin
            walk_va   = rq.virtual_address;
            walk_read = rq.access_read;
            walk_user = rq.user_mode;
            if (!xlat_on) begin
                walk_phase           = PH_IDLE;
                rsp.kind             = KIND_DONE;
                rsp.physical_address = walk_va;
            end else begin
                walk_phase        = PH_L1;
                rsp.kind          = KIND_FETCH;
                rsp.fetch_address = first_level_addr(walk_va);
            end
            return 1'b1;
        end
        d = rq.descriptor;
        case (walk_phase)
            PH_L1: begin
                case (d[1:0])
                    L1_TABLE: begin
                        walk_phase        = PH_L2;
                        rsp.kind          = KIND_FETCH;
                        rsp.fetch_address = ((d & MASK_L2_TABLE) |
                                             ((walk_va & MASK_L2_INDEX) >> 10)) & MASK_WORD;
                    end
                    L1_SECTION: begin
                        walk_phase = PH_IDLE;
                        rsp.kind   = KIND_DONE;
                        if ((d & MASK_SUPER_FLAG) != 0)
                            pa = (d & MASK_SUPERSECT) | (walk_va & ~MASK_SUPERSECT);
                        else
                            pa = (d & MASK_SECTION) | (walk_va & ~MASK_SECTION);
                        if (access_allowed(d[11:10]))
                            rsp.physical_address = pa;
                        else
                            rsp.fault = FAULT_SECTION_PERM;
                    end
                    default: begin
                        walk_phase = PH_IDLE;
                        rsp.kind   = KIND_DONE;
                        rsp.fault  = FAULT_SECTION_XLAT;
                    end
                endcase
                return 1'b1;
            end
            PH_L2: begin
                walk_phase = PH_IDLE;
                rsp.kind   = KIND_DONE;
                case (d[1:0])
                    L2_FAULT: begin
                        rsp.fault = FAULT_PAGE_XLAT;
                        return 1'b1;
                    end
                    L2_LARGE: pa = (d & MASK_LARGE_PAGE) | (walk_va & ~MASK_LARGE_PAGE);
                    default:  pa = (d & MASK_SMALL_PAGE) | (walk_va & ~MASK_SMALL_PAGE);
                endcase
                if (access_allowed(d[5:4]))
                    rsp.physical_address = pa;
                else
                    rsp.fault = FAULT_PAGE_PERM;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // check accepted responses first, then track config writes and requests
    always @(posedge i_clk) begin
        t_walk_rsp want;
        t_walk_rsp due;
        if (i_rst_n) begin
            if (o_rsp_valid && !i_rsp_stall) begin
                if (pending_rsp_q.size() == 0) begin
                    report_mismatch($sformatf("response %h with nothing outstanding", o_rsp));
                end else begin
                    want = pending_rsp_q.pop_front();
                    if (o_rsp.kind !== want.kind)
                        report_mismatch($sformatf("kind %b, wanted %b", o_rsp.kind, want.kind));
                    if (o_rsp.fetch_address !== want.fetch_address)
                        report_mismatch($sformatf("fetch_address %h, wanted %h",
                                                  o_rsp.fetch_address, want.fetch_address));
                    if (o_rsp.physical_address !== want.physical_address)
                        report_mismatch($sformatf("physical_address %h, wanted %h",
                                                  o_rsp.physical_address,
                                                  want.physical_address));
                    if (o_rsp.fault !== want.fault)
                        report_mismatch($sformatf("fault %0d, wanted %0d",
                                                  o_rsp.fault, want.fault));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MMU_ENABLE:      xlat_on   = i_cfg_data[0];
                    CFG_SYSTEM_PROTECT:  sys_prot  = i_cfg_data[0];
                    CFG_ROM_PROTECT:     rom_prot  = i_cfg_data[0];
                    CFG_TABLE_SPLIT:     split_n   = i_cfg_data[2:0];
                    CFG_TABLE_BASE_ZERO: base_zero = i_cfg_data;
                    CFG_TABLE_BASE_ONE:  base_one  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && !o_req_stall) begin
                if (predict_walk_step(i_req, due))
                    pending_rsp_q.push_back(due);
            end
        end
    end

    // response stall pattern: free, sparse random, long holds, regular on/off
    always @(negedge i_clk) begin
        stall_ticks <= stall_ticks + 8'd1;
        case (stall_ticks[7:6])
            2'd0:    i_rsp_stall <= 1'b0;
            2'd1:    i_rsp_stall <= ($urandom_range(2) == 0);
            2'd2:    i_rsp_stall <= ($urandom_range(7) == 0) ? ~i_rsp_stall : i_rsp_stall;
            default: i_rsp_stall <= stall_ticks[2];
        endcase
    end

    // run guard
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // drive one request and hold it until taken, then maybe pause the burst
    task automatic send_request(input t_walk_req rq);
        @(negedge i_clk);
        i_req       = rq;
        i_req_valid = 1'b1;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            i_req_valid = 1'b0;
            repeat ($urandom_range(5)) @(negedge i_clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 20) : $urandom_range(6);
        end
    endtask

    task automatic send_translate(input logic [31:0] va, input logic rd, input logic usr);
        t_walk_req rq;
        rq.action          = ACT_TRANSLATE;
        rq.virtual_address = va;
        rq.access_read     = rd;
        rq.user_mode       = usr;
        rq.descriptor      = $urandom;
        send_request(rq);
    endtask

    task automatic send_reply(input logic [31:0] d);
        t_walk_req rq;
        rq.action          = ACT_REPLY;
        rq.virtual_address = $urandom;
        rq.access_read     = 1'($urandom_range(1));
        rq.user_mode       = 1'($urandom_range(1));
        rq.descriptor      = d;
        send_request(rq);
    endtask

    // drop valid and let every outstanding response drain
    task automatic wait_idle();
        @(negedge i_clk);
        i_req_valid = 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic set_regs(input logic mmu, input logic s, input logic r,
                            input logic [2:0] n, input logic [31:0] b0, input logic [31:0] b1);
        wait_idle();
        write_reg(CFG_MMU_ENABLE, {31'd0, mmu});
        write_reg(CFG_SYSTEM_PROTECT, {31'd0, s});
        write_reg(CFG_ROM_PROTECT, {31'd0, r});
        write_reg(CFG_TABLE_SPLIT, {29'd0, n});
        write_reg(CFG_TABLE_BASE_ZERO, b0);
        write_reg(CFG_TABLE_BASE_ONE, b1);
    endtask

    // mmu off after reset: identity mapping, stray replies ignored
    task automatic test_passthrough();
        send_translate(32'h0000_0000, 1'b0, 1'b0);
        send_translate(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_reply(32'hFFFF_FFFF);
        send_reply(32'h0000_0000);
    endtask

    // all registers, unused indexes, both table bases at the split extremes
    task automatic test_register_map();
        set_regs(1'b1, 1'b1, 1'b0, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h0000_0000);
        send_translate(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_reply(32'hFFFF_FC02);
        set_regs(1'b1, 1'b0, 1'b1, 3'd7, 32'h0000_0000, 32'h0000_0000);
        send_translate(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_reply(32'h0000_0002);
        send_translate(32'h01FF_FFFF, 1'b1, 1'b1);
        send_reply(32'h0000_0003);
    endtask

    // descriptor types at both levels, faults and permissions
    task automatic test_descriptor_types();
        set_regs(1'b1, 1'b1, 1'b0, 3'd2, 32'h1234_5678, 32'h8765_4321);
        send_translate(32'h1234_5678, 1'b1, 1'b1);
        send_reply(32'h0000_0000);
        send_translate(32'h0ABC_DEF0, 1'b1, 1'b1);
        send_reply(32'hABCD_E401);
        send_reply(32'h5555_0011);
        send_translate(32'hC000_1234, 1'b1, 1'b0);
        send_reply(32'h0000_0401);
        send_reply(32'h0000_0000);
        send_translate(32'h3FFF_FFFF, 1'b0, 1'b0);
        send_reply(32'hFFFF_FFFD);
        send_reply(32'hFFFF_F03E);
    endtask

    // a new translate drops the walk in progress at either level
    task automatic test_abandon();
        send_translate(32'h4000_0000, 1'b1, 1'b0);
        send_translate(32'h7654_3210, 1'b0, 1'b1);
        send_reply(32'h0001_0802);
        send_translate(32'h0000_F000, 1'b1, 1'b0);
        send_reply(32'h0000_0C01);
        send_translate(32'h0010_0000, 1'b1, 1'b0);
        send_reply(32'hFFF0_0C02);
    endtask

    // one walk with random content, sometimes broken or abandoned
    task automatic send_walk();
        logic [31:0] va;
        logic [31:0] d;
        int unsigned pick;
        va = $urandom;
        if ($urandom_range(3) == 0) va = va >> $urandom_range(12, 1);
        pick = $urandom_range(19);
        if (pick == 0) send_reply($urandom);
        send_translate(va, 1'($urandom_range(1)), 1'($urandom_range(1)));
        if (!xlat_on || pick == 1) return;
        d    = $urandom;
        pick = $urandom_range(9);
        if (pick < 4) begin
            d[1:0] = L1_TABLE;
        end else if (pick < 8) begin
            d[1:0] = L1_SECTION;
            if ($urandom_range(1) != 0) d[17:16] = 2'b00;
        end
        send_reply(d);
        if (d[1:0] != L1_TABLE || $urandom_range(15) == 0) return;
        d = $urandom;
        if ($urandom_range(7) == 0) d[1:0] = L2_FAULT;
        send_reply(d);
    endtask

    // phases of random walks over a spread of register settings
    task automatic test_random_walks();
        int unsigned target;
        logic [2:0]  n;
        logic [31:0] b0;
        logic [31:0] b1;
        for (int ph = 0; ph < WALK_PHASES; ph++) begin
            n  = (ph < 8) ? ph[2:0] : 3'($urandom_range(7));
            b0 = (ph % 4 == 0) ? 32'h0000_0000 : (ph % 4 == 1) ? 32'hFFFF_FFFF : $urandom;
            b1 = (ph % 4 == 1) ? 32'h0000_0000 : (ph % 4 == 0) ? 32'hFFFF_FFFF : $urandom;
            set_regs(ph % 6 != 5, (ph < 4) ? ph[0] : 1'($urandom_range(1)),
                     (ph < 4) ? ph[1] : 1'($urandom_range(1)), n, b0, b1);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) send_walk();
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_passthrough();
        test_register_map();
        test_descriptor_types();
        test_abandon();
        test_random_walks();
        wait_idle();
        repeat (5) @(posedge i_clk);
        if (pending_rsp_q.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", pending_rsp_q.size()));
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/tlpw_pkg.sv
hdl/two_level_page_table_walker_unit.sv
bench/tb_two_level_page_table_walker_unit.sv
